// ===== sv/lwpf_pkg.sv =====
// Shared types, codes and constants of the LCD window packet framer.
package lwpf_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PIXEL = 2'd1,
    OP_END   = 2'd2,
    OP_LIGHT = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [1:0] CFG_X_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_Y_OFFSET   = 2'd2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Result cap per item and the width of the counter that tracks it.
  localparam int MAX_RESULTS = 64;
  localparam int OCNT_W      = 7;

  // Stream byte codes.
  localparam logic [7:0]  TYPE_DATA      = 8'h00;
  localparam logic [7:0]  TYPE_WINDOW    = 8'h01;
  localparam logic [7:0]  LIGHT_ON_BYTE  = 8'h02;
  localparam logic [7:0]  LIGHT_OFF_BYTE = 8'h03;
  localparam logic [63:0] PAD_WORD       = {64{1'b1}};

  // One input item.
  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] y_start;
    logic [7:0] y_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       light_on;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [63:0] stream_word;
    logic        last;
  } result_t;

  // Source of an emitted word.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_WINDOW = 2'd1,
    KIND_PAD    = 2'd2,
    KIND_LIGHT  = 2'd3
  } word_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr_byte;
    logic       emit;
    word_kind_t kind;
    logic       last;
    logic       wp_clear;
    logic       pib_inc;
    logic       pib_clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    pkt_open;
    logic    bytes_left;
    logic    close_now;
    logic    pib_wrap;
    logic    pib_zero;
    logic    out_free;
  } dp_status_t;

endpackage

// ===== sv/lcd_window_packet_framer.sv =====
// Flow: an accepted start, end or backlight transaction is captured, passes through the dispatch
// state, and then its first word, if any, is registered into the output register. One transaction
// at a time; words leave one per cycle while the output is not stalled. Window and closed packets
// are PACKET_BYTES/8 words each; a backlight block is BLOCK_BYTES/8 words, capped at MAX_RESULTS.
// Reset clears the packet store, write position, block count, pair state, configuration, byte count
// and output valid; the rest of the captured item and the output payload are not reset.
module lcd_window_packet_framer #(
  parameter int PACKET_BYTES = 64,
  parameter int BLOCK_BYTES  = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lwpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lwpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  lwpf_pkg::item_t                  item_data,
  output logic                             res_valid,
  input  logic                             res_stall,
  output lwpf_pkg::result_t                res_data
);

  localparam int PW = PACKET_BYTES / 8;
  localparam int BW = BLOCK_BYTES / 8;
  localparam int CW = $clog2((PW > BW) ? PW : BW);

  lwpf_pkg::dp_cmd_t    dp_cmd;
  lwpf_pkg::dp_status_t dp_status;
  logic [CW-1:0]        word_idx;

  // Sequencer.
  lwpf_ctrl #(
    .PACKET_BYTES(PACKET_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .status    (dp_status),
    .cmd       (dp_cmd),
    .word_idx  (word_idx)
  );

  // Packet store and output.
  lwpf_datapath #(
    .PACKET_BYTES(PACKET_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item_data(item_data),
    .cmd      (dp_cmd),
    .word_idx (word_idx),
    .status   (dp_status),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  // A word is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit |-> dp_status.out_free)
    else $error("word loaded over a held output transaction");

  // No word is produced while the controller waits for a transaction.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !dp_cmd.emit)
    else $error("word emitted while idle");

  // The store is never written and read out in the same cycle.
  a_wr_emit: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.wr_byte |-> !dp_cmd.emit)
    else $error("byte write collides with word emission");

endmodule

// ===== sv/lwpf_datapath.sv =====
// Datapath of the framer: packet store, pixel packing, word selection and output register.
module lwpf_datapath #(
  parameter int PACKET_BYTES = 64,
  parameter int BLOCK_BYTES  = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lwpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lwpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lwpf_pkg::item_t                 item_data,
  input  lwpf_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(((PACKET_BYTES / 8) > (BLOCK_BYTES / 8)) ?
                       (PACKET_BYTES / 8) : (BLOCK_BYTES / 8))-1:0] word_idx,
  output lwpf_pkg::dp_status_t            status,
  output logic                            res_valid,
  input  logic                            res_stall,
  output lwpf_pkg::result_t               res_data
);

  localparam int NW      = (PACKET_BYTES + 7) / 8;
  localparam int WPW     = $clog2(PACKET_BYTES);
  localparam int WIW     = WPW - 3;
  localparam int PPB_RAW = BLOCK_BYTES / PACKET_BYTES;
  localparam int PPB     = (PPB_RAW < 1) ? 1 : PPB_RAW;
  localparam int PIBW    = (PPB > 1) ? $clog2(PPB) : 1;

  // Configuration registers.
  logic       color_mode;
  logic [7:0] x_offset;
  logic [7:0] y_offset;

  // Captured item.
  lwpf_pkg::opcode_t op;
  logic [31:0]       win_bytes;
  logic              light_on;
  logic [23:0]       pix_bytes;
  logic [1:0]        nbytes;

  // Packet state.
  logic [63:0]     store [NW];
  logic [WPW-1:0]  wp;
  logic [PIBW-1:0] pib;
  logic [11:0]     held;
  logic            phase;

  logic [15:0]     c565;
  logic [11:0]     px444;
  logic [7:0]      xs_m;
  logic [7:0]      xe_m;
  logic [31:0]     win_next;
  logic [WPW-1:0]  wp_eff;
  logic            close_now;
  logic [WIW-1:0]  wr_widx;
  logic [2:0]      wr_lane;
  logic [WIW-1:0]  rd_widx;
  logic [8:0]      wp_wide;
  logic [7:0]      hdr;
  logic            idx_zero;
  logic            out_free;
  logic            pib_wrap;
  logic [63:0]     word;

  // Pixel packing and window adjustment from the incoming item.
  always_comb begin
    c565  = {item_data.red[7:3], item_data.green[7:2], item_data.blue[7:3]};
    px444 = {item_data.red[7:4], item_data.green[7:4], item_data.blue[7:4]};
    if (color_mode) begin
      xs_m = {item_data.x_start[7:1], 1'b0};
      xe_m = item_data.x_end + {7'd0, ~item_data.x_end[0]};
    end else begin
      xs_m = item_data.x_start;
      xe_m = item_data.x_end;
    end
    win_next = {xs_m + x_offset, xe_m + x_offset,
                item_data.y_start + y_offset, item_data.y_end + y_offset};
  end

  // Byte placement: a closed packet starts at its first data byte.
  assign wp_eff    = (wp == '0) ? WPW'(2) : wp;
  assign close_now = (wp_eff == WPW'(PACKET_BYTES - 1));
  assign wr_widx   = wp_eff[WPW-1:3];
  assign wr_lane   = wp_eff[2:0];
  assign rd_widx   = WIW'(word_idx);
  assign wp_wide   = 9'(wp);
  assign hdr       = wp_wide[7:0] - 8'd1;
  assign idx_zero  = (word_idx == '0);
  assign out_free  = !res_valid || !res_stall;
  assign pib_wrap  = (pib == PIBW'(PPB - 1));

  // Status to the controller.
  always_comb begin
    status.op         = op;
    status.pkt_open   = (wp != '0);
    status.bytes_left = (nbytes != 2'd0);
    status.close_now  = close_now;
    status.pib_wrap   = pib_wrap;
    status.pib_zero   = (pib == '0);
    status.out_free   = out_free;
  end

  // Word selection for the output register.
  always_comb begin
    unique case (cmd.kind)
      lwpf_pkg::KIND_DATA: begin
        word = idx_zero ? {lwpf_pkg::TYPE_DATA, hdr, store[0][47:0]} : store[rd_widx];
      end
      lwpf_pkg::KIND_WINDOW: begin
        word = idx_zero ? {lwpf_pkg::TYPE_WINDOW, win_bytes, 24'h000000} : 64'd0;
      end
      lwpf_pkg::KIND_PAD: begin
        word = lwpf_pkg::PAD_WORD;
      end
      lwpf_pkg::KIND_LIGHT: begin
        if (idx_zero) begin
          word = {(light_on ? lwpf_pkg::LIGHT_ON_BYTE : lwpf_pkg::LIGHT_OFF_BYTE),
                  lwpf_pkg::PAD_WORD[55:0]};
        end else begin
          word = lwpf_pkg::PAD_WORD;
        end
      end
      default: begin
        word = lwpf_pkg::PAD_WORD;
      end
    endcase
  end

  // Packet store: byte writes, and each word is cleared as it is sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NW; w++) begin
        store[w] <= '0;
      end
    end else if (cmd.wr_byte) begin
      store[wr_widx][{~wr_lane, 3'b000} +: 8] <= pix_bytes[23:16];
    end else if (cmd.emit && cmd.kind == lwpf_pkg::KIND_DATA) begin
      store[rd_widx] <= '0;
    end
  end

  // Control state: configuration, write position, block count, pair state, byte count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b0;
      x_offset   <= 8'd0;
      y_offset   <= 8'd0;
      wp         <= '0;
      pib        <= '0;
      held       <= 12'd0;
      phase      <= 1'b0;
      nbytes     <= 2'd0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lwpf_pkg::CFG_COLOR_MODE: color_mode <= cfg_data[0];
          lwpf_pkg::CFG_X_OFFSET:   x_offset   <= cfg_data;
          lwpf_pkg::CFG_Y_OFFSET:   y_offset   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        unique case (item_data.opcode)
          lwpf_pkg::OP_PIXEL: begin
            if (!color_mode) begin
              nbytes <= 2'd2;
            end else if (!phase) begin
              nbytes <= 2'd0;
              held   <= px444;
              phase  <= 1'b1;
            end else begin
              nbytes <= 2'd3;
              held   <= 12'd0;
              phase  <= 1'b0;
            end
          end
          lwpf_pkg::OP_START, lwpf_pkg::OP_END: begin
            nbytes <= 2'd0;
            held   <= 12'd0;
            phase  <= 1'b0;
          end
          default: begin
            nbytes <= 2'd0;
          end
        endcase
      end else if (cmd.wr_byte) begin
        nbytes <= nbytes - 2'd1;
      end
      if (cmd.wr_byte) begin
        wp <= close_now ? wp_eff : wp_eff + WPW'(1);
      end else if (cmd.wp_clear) begin
        wp <= '0;
      end
      if (cmd.pib_clear) begin
        pib <= '0;
      end else if (cmd.pib_inc) begin
        pib <= pib_wrap ? '0 : pib + PIBW'(1);
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Item payload and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= item_data.opcode;
      win_bytes <= win_next;
      light_on  <= item_data.light_on;
      if (color_mode) begin
        pix_bytes <= {held, px444};
      end else begin
        pix_bytes <= {c565, 8'h00};
      end
    end else if (cmd.wr_byte) begin
      pix_bytes <= {pix_bytes[15:0], 8'h00};
    end
    if (cmd.emit) begin
      res_data.stream_word <= word;
      res_data.last        <= cmd.last;
    end
  end

endmodule

// ===== sv/lwpf_ctrl.sv =====
// Controller of the framer: sequences byte writes and word runs for each transaction.
module lwpf_ctrl #(
  parameter int PACKET_BYTES = 64,
  parameter int BLOCK_BYTES  = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  lwpf_pkg::dp_status_t status,
  output lwpf_pkg::dp_cmd_t    cmd,
  output logic [$clog2(((PACKET_BYTES / 8) > (BLOCK_BYTES / 8)) ?
                       (PACKET_BYTES / 8) : (BLOCK_BYTES / 8))-1:0] word_idx
);

  localparam int PW = PACKET_BYTES / 8;
  localparam int BW = BLOCK_BYTES / 8;
  localparam int CW = $clog2((PW > BW) ? PW : BW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WR_BYTE,
    S_EMIT_DATA,
    S_EMIT_WIN,
    S_PAD,
    S_LIGHT
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [lwpf_pkg::OCNT_W-1:0]  ocnt;
  logic [lwpf_pkg::OCNT_W-1:0]  ocnt_next;
  logic                         pkt_end;
  logic                         run_end;
  logic                         cap;

  assign item_stall = (state != S_IDLE);
  assign word_idx   = cnt;
  assign pkt_end    = (cnt == CW'(PW - 1));
  assign run_end    = (cnt == CW'(BW - 1));
  assign cap        = (ocnt == lwpf_pkg::OCNT_W'(lwpf_pkg::MAX_RESULTS - 1));

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ocnt_next  = ocnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          ocnt_next  = '0;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_next = '0;
        unique case (status.op)
          lwpf_pkg::OP_START: state_next = status.pkt_open ? S_EMIT_DATA : S_EMIT_WIN;
          lwpf_pkg::OP_PIXEL: state_next = S_WR_BYTE;
          lwpf_pkg::OP_END: begin
            if (status.pkt_open) begin
              state_next = S_EMIT_DATA;
            end else begin
              state_next = status.pib_zero ? S_IDLE : S_PAD;
            end
          end
          default: state_next = S_LIGHT;
        endcase
      end
      S_WR_BYTE: begin
        if (!status.bytes_left) begin
          state_next = S_IDLE;
        end else begin
          cmd.wr_byte = 1'b1;
          if (status.close_now) begin
            state_next = S_EMIT_DATA;
          end
        end
      end
      S_EMIT_DATA: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lwpf_pkg::KIND_DATA;
          cmd.last  = pkt_end && (status.op == lwpf_pkg::OP_PIXEL ||
                                  (status.op == lwpf_pkg::OP_END && status.pib_wrap));
          cnt_next  = cnt + 1'b1;
          ocnt_next = ocnt + 1'b1;
          if (pkt_end) begin
            cmd.wp_clear = 1'b1;
            cmd.pib_inc  = 1'b1;
            cnt_next     = '0;
            unique case (status.op)
              lwpf_pkg::OP_START: state_next = S_EMIT_WIN;
              lwpf_pkg::OP_PIXEL: state_next = S_WR_BYTE;
              lwpf_pkg::OP_END:   state_next = status.pib_wrap ? S_IDLE : S_PAD;
              default:            state_next = S_IDLE;
            endcase
          end
        end
      end
      S_EMIT_WIN: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lwpf_pkg::KIND_WINDOW;
          cmd.last  = pkt_end;
          cnt_next  = cnt + 1'b1;
          ocnt_next = ocnt + 1'b1;
          if (pkt_end) begin
            cmd.pib_inc = 1'b1;
            cnt_next    = '0;
            state_next  = S_IDLE;
          end
        end
      end
      S_PAD: begin
        // Pad packets advance the block count until it wraps or the cap clears it.
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lwpf_pkg::KIND_PAD;
          cmd.last  = (pkt_end && status.pib_wrap) || cap;
          cnt_next  = cnt + 1'b1;
          ocnt_next = ocnt + 1'b1;
          if (cap) begin
            cmd.pib_clear = 1'b1;
            cnt_next      = '0;
            state_next    = S_IDLE;
          end else if (pkt_end) begin
            cmd.pib_inc = 1'b1;
            cnt_next    = '0;
            if (status.pib_wrap) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_LIGHT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lwpf_pkg::KIND_LIGHT;
          cmd.last  = run_end || cap;
          cnt_next  = cnt + 1'b1;
          ocnt_next = ocnt + 1'b1;
          if (run_end || cap) begin
            cnt_next   = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ocnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ocnt  <= ocnt_next;
    end
  end

endmodule
